// ----- hw/rtl/pcc_pkg.sv -----
// shared types, result codes and character constants for the pileup consensus caller
package pcc_pkg;

    localparam int NAME_MAX_DEF   = 30;
    localparam int COUNT_BITS_DEF = 16;
    localparam int POS_BITS_DEF   = 32;

    localparam int BYTE_W = 8;
    localparam int RUN_W  = 32;
    localparam int SKIP_W = 16;
    localparam logic [SKIP_W-1:0] SKIP_SAT = 16'hFFFF;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // result select codes
    localparam logic [2:0] RES_NONE = 3'd0;
    localparam logic [2:0] RES_CONS = 3'd1;
    localparam logic [2:0] RES_RUN  = 3'd2;
    localparam logic [2:0] RES_NL   = 3'd3;
    localparam logic [2:0] RES_GT   = 3'd4;
    localparam logic [2:0] RES_NAME = 3'd5;
    localparam logic [2:0] RES_END  = 3'd6;

    typedef struct packed {
        logic             kind;
        logic [7:0]       out_char;
        logic [RUN_W-1:0] run_length;
        logic             last;
    } res_t;

    typedef struct packed {
        logic       name_wr;
        logic       name_commit;
        logic       pos_clr;
        logic       pos_digit;
        logic       pos_finish;
        logic       ref_load;
        logic       bump_read;
        logic       line_end;
        logic       skip_clr;
        logic       skip_digit;
        logic       skip_dec;
        logic       hdr_mode;
        logic       hdr_inc;
        logic [2:0] res_sel;
    } cmd_t;

    typedef struct packed {
        logic is_tab;
        logic is_nl;
        logic is_digit;
        logic is_indel;
        logic is_caret;
        logic name_room;
        logic hdr_needed;
        logic record_open;
        logic name_empty;
        logic hdr_last;
        logic run_needed;
        logic skip_zero;
        logic skip_one;
    } sts_t;

    // counter index to base letter, order A C T G
    function automatic logic [7:0] base_letter(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_A;
            2'd1:    ch = CH_C;
            2'd2:    ch = CH_T;
            default: ch = CH_G;
        endcase
        return ch;
    endfunction

endpackage

// ----- hw/rtl/pileup_consensus_caller.sv -----
// top level of the pileup majority consensus caller
//
// channel   dir  tdata                         tuser  tlast
// s_*       in   [7:0] in_byte                 -      -
// m_*       out  [7:0] out_char, [39:8] run    kind   last result of the input item
//
// one input item per cycle while the two-entry output buffer has room and no header is being sent
// a name change holds the input while the header goes out: a newline if a record is open, then >, the name, a newline
// no clearing pass: input is taken as soon as reset is released
// m_tready low fills the output buffer, then s_tready drops until an item leaves
module pileup_consensus_caller
#(
    parameter int NAME_MAX   = pcc_pkg::NAME_MAX_DEF,
    parameter int COUNT_BITS = pcc_pkg::COUNT_BITS_DEF,
    parameter int POS_BITS   = pcc_pkg::POS_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // in_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pcc_pkg::RUN_W+7:0] m_tdata,   // out_char, run_length
    output logic                      m_tuser,   // kind
    output logic                      m_tlast
);

    pcc_pkg::cmd_t cmd;
    pcc_pkg::sts_t sts;
    pcc_pkg::res_t res;
    logic          push;
    logic          full;

    pcc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .full     (full),
        .sts      (sts),
        .cmd      (cmd),
        .push     (push)
    );

    pcc_datapath
    #(
        .NAME_MAX   (NAME_MAX),
        .COUNT_BITS (COUNT_BITS),
        .POS_BITS   (POS_BITS)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .res     (res)
    );

    pcc_obuf u_obuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res      (res),
        .full     (full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hw/rtl/pcc_obuf.sv -----
// two-entry output buffer between the result source and the master stream
module pcc_obuf
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  pcc_pkg::res_t                     res,
    output logic                              full,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcc_pkg::RUN_W+7:0]         m_tdata,  // out_char, run_length
    output logic                              m_tuser,  // kind
    output logic                              m_tlast
);

    pcc_pkg::res_t ent_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          pop;
    pcc_pkg::res_t head;

    assign full     = (cnt_reg == 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = ent_reg[rd_ptr_reg];
    assign m_tdata  = {head.run_length, head.out_char};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ----- hw/rtl/pcc_datapath.sv -----
// datapath: name store, position tracking, base counters, indel skip and result forming
module pcc_datapath
#(
    parameter int NAME_MAX   = pcc_pkg::NAME_MAX_DEF,
    parameter int COUNT_BITS = pcc_pkg::COUNT_BITS_DEF,
    parameter int POS_BITS   = pcc_pkg::POS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  pcc_pkg::cmd_t       cmd,
    output pcc_pkg::sts_t       sts,
    output pcc_pkg::res_t       res
);

    localparam int NP_W = $clog2(NAME_MAX + 1);
    localparam int NA_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam logic [NP_W-1:0] NAME_LIMIT = NP_W'(NAME_MAX);

    logic [7:0]            name_mem [NAME_MAX];
    logic [7:0]            rd_data_reg;
    logic [NA_W-1:0]       rd_addr;
    logic [NP_W-1:0]       rd_sel;

    logic [NP_W-1:0]       name_pos_reg, name_pos_next;
    logic [NP_W-1:0]       name_len_reg;
    logic [NP_W-1:0]       hdr_idx_reg;
    logic                  name_changed_reg, name_changed_next;
    logic                  record_open_reg;

    logic [POS_BITS-1:0]   pos_reg;
    logic [POS_BITS:0]     last_p1_reg;
    logic [POS_BITS-1:0]   pos_x10;
    logic [POS_BITS-1:0]   run_val;

    logic [7:0]            ref_reg;
    logic [COUNT_BITS-1:0] cnt_reg [4];
    logic                  is_base;
    logic                  is_dotcomma;
    logic                  bump_en;
    logic [1:0]            bump_idx;

    logic [pcc_pkg::SKIP_W-1:0] skip_reg;
    logic [pcc_pkg::SKIP_W+3:0] skip_wide;

    logic                  w01;
    logic                  w23;
    logic [COUNT_BITS-1:0] m01;
    logic [COUNT_BITS-1:0] m23;
    logic [1:0]            best;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [7:0]            cons_char;

    // byte classes and status flags
    always_comb
    begin
        sts.is_tab   = (in_byte == pcc_pkg::CH_TAB);
        sts.is_nl    = (in_byte == pcc_pkg::CH_NL);
        sts.is_digit = (in_byte >= pcc_pkg::CH_0) && (in_byte <= pcc_pkg::CH_9);
        sts.is_indel = (in_byte == pcc_pkg::CH_PLUS) || (in_byte == pcc_pkg::CH_MINUS);
        sts.is_caret = (in_byte == pcc_pkg::CH_CARET);
        is_base      = (in_byte == pcc_pkg::CH_A)  || (in_byte == pcc_pkg::CH_C)
                    || (in_byte == pcc_pkg::CH_G)  || (in_byte == pcc_pkg::CH_T)
                    || (in_byte == pcc_pkg::CH_LA) || (in_byte == pcc_pkg::CH_LC)
                    || (in_byte == pcc_pkg::CH_LG) || (in_byte == pcc_pkg::CH_LT);
        is_dotcomma  = (in_byte == pcc_pkg::CH_DOT) || (in_byte == pcc_pkg::CH_COMMA);

        sts.name_room   = (name_pos_reg < NAME_LIMIT);
        sts.hdr_needed  = name_changed_reg || (name_pos_reg != name_len_reg);
        sts.record_open = record_open_reg;
        sts.name_empty  = (name_pos_reg == '0);
        sts.hdr_last    = ((hdr_idx_reg + NP_W'(1)) == name_pos_reg);
        sts.run_needed  = ({1'b0, pos_reg} > last_p1_reg);
        sts.skip_zero   = (skip_reg == '0);
        sts.skip_one    = (skip_reg == pcc_pkg::SKIP_W'(1));
    end

    // name state
    always_comb
    begin
        name_pos_next = name_pos_reg;
        if (cmd.line_end)
        begin
            name_pos_next = '0;
        end
        else if (cmd.name_wr)
        begin
            name_pos_next = name_pos_reg + NP_W'(1);
        end

        name_changed_next = name_changed_reg;
        if (cmd.line_end)
        begin
            name_changed_next = 1'b0;
        end
        else if (cmd.name_wr && ((name_pos_reg >= name_len_reg) || (rd_data_reg != in_byte)))
        begin
            name_changed_next = 1'b1;
        end

        if (cmd.hdr_mode)
        begin
            rd_sel = cmd.hdr_inc ? (hdr_idx_reg + NP_W'(1)) : hdr_idx_reg;
        end
        else
        begin
            rd_sel = name_pos_next;
        end
        rd_addr = (rd_sel < NAME_LIMIT) ? rd_sel[NA_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.name_wr)
        begin
            name_mem[name_pos_reg[NA_W-1:0]] <= in_byte;
        end
        rd_data_reg <= name_mem[rd_addr];
    end

    // position
    assign pos_x10        = (pos_reg << 3) + (pos_reg << 1);
    assign run_val        = pos_reg - last_p1_reg[POS_BITS-1:0];

    // indel length
    assign skip_wide     = ({4'b0, skip_reg} << 3) + ({4'b0, skip_reg} << 1)
                         + {{(pcc_pkg::SKIP_W){1'b0}}, in_byte[3:0]};

    // base counters
    always_comb
    begin
        bump_idx = is_base ? in_byte[2:1] : ref_reg[2:1];
        bump_en  = cmd.bump_read
                && (is_base || (is_dotcomma && (ref_reg != pcc_pkg::CH_N)));
    end

    // majority with ties to the earlier base
    always_comb
    begin
        w01       = (cnt_reg[1] > cnt_reg[0]);
        m01       = w01 ? cnt_reg[1] : cnt_reg[0];
        w23       = (cnt_reg[3] > cnt_reg[2]);
        m23       = w23 ? cnt_reg[3] : cnt_reg[2];
        if (m23 > m01)
        begin
            best     = {1'b1, w23};
            best_cnt = m23;
        end
        else
        begin
            best     = {1'b0, w01};
            best_cnt = m01;
        end
        cons_char = (best_cnt == '0) ? pcc_pkg::CH_N : pcc_pkg::base_letter(best);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_pos_reg     <= '0;
            name_len_reg     <= '0;
            hdr_idx_reg      <= '0;
            name_changed_reg <= 1'b0;
            record_open_reg  <= 1'b0;
            pos_reg          <= '0;
            last_p1_reg      <= (POS_BITS + 1)'(1);
            ref_reg          <= '0;
            skip_reg         <= '0;
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            name_pos_reg     <= name_pos_next;
            name_changed_reg <= name_changed_next;
            if (cmd.name_commit)
            begin
                name_len_reg    <= name_pos_reg;
                record_open_reg <= (name_pos_reg != '0);
                hdr_idx_reg     <= '0;
            end
            else if (cmd.hdr_inc)
            begin
                hdr_idx_reg <= hdr_idx_reg + NP_W'(1);
            end

            if (cmd.pos_clr)
            begin
                pos_reg <= '0;
            end
            else if (cmd.pos_digit)
            begin
                pos_reg <= pos_x10 + {{(POS_BITS-4){1'b0}}, in_byte[3:0]};
            end
            if (cmd.pos_finish)
            begin
                last_p1_reg <= {1'b0, pos_reg} + (POS_BITS + 1)'(1);
            end

            if (cmd.ref_load)
            begin
                ref_reg <= in_byte;
            end

            if (cmd.skip_clr)
            begin
                skip_reg <= '0;
            end
            else if (cmd.skip_digit)
            begin
                skip_reg <= (skip_wide > {4'b0, pcc_pkg::SKIP_SAT})
                          ? pcc_pkg::SKIP_SAT : skip_wide[pcc_pkg::SKIP_W-1:0];
            end
            else if (cmd.skip_dec && !sts.skip_zero)
            begin
                skip_reg <= skip_reg - pcc_pkg::SKIP_W'(1);
            end

            if (cmd.line_end)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    cnt_reg[i] <= '0;
                end
            end
            else if (bump_en && (cnt_reg[bump_idx] != {COUNT_BITS{1'b1}}))
            begin
                cnt_reg[bump_idx] <= cnt_reg[bump_idx] + COUNT_BITS'(1);
            end
        end
    end

    // result forming
    always_comb
    begin
        res = '0;
        case (cmd.res_sel)
            pcc_pkg::RES_CONS:
            begin
                res.out_char = cons_char;
                res.last     = 1'b1;
            end
            pcc_pkg::RES_RUN:
            begin
                res.kind       = 1'b1;
                res.out_char   = pcc_pkg::CH_N;
                res.run_length = pcc_pkg::RUN_W'(run_val);
                res.last       = 1'b1;
            end
            pcc_pkg::RES_NL:
            begin
                res.out_char = pcc_pkg::CH_NL;
            end
            pcc_pkg::RES_GT:
            begin
                res.out_char = pcc_pkg::CH_GT;
            end
            pcc_pkg::RES_NAME:
            begin
                res.out_char = rd_data_reg;
            end
            pcc_pkg::RES_END:
            begin
                res.out_char = pcc_pkg::CH_NL;
                res.last     = 1'b1;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/pcc_ctrl.sv -----
// controller: field parser and header sequencer
module pcc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          full,
    input  pcc_pkg::sts_t sts,
    output pcc_pkg::cmd_t cmd,
    output logic          push
);

    localparam logic [3:0] ST_NAME       = 4'd0;
    localparam logic [3:0] ST_POS        = 4'd1;
    localparam logic [3:0] ST_POS_SKIP   = 4'd2;
    localparam logic [3:0] ST_REF        = 4'd3;
    localparam logic [3:0] ST_REF_SKIP   = 4'd4;
    localparam logic [3:0] ST_DEPTH_SKIP = 4'd5;
    localparam logic [3:0] ST_READS      = 4'd6;
    localparam logic [3:0] ST_INDEL_NUM  = 4'd7;
    localparam logic [3:0] ST_INDEL_SKIP = 4'd8;
    localparam logic [3:0] ST_QUAL       = 4'd9;
    localparam logic [3:0] ST_TRAIL      = 4'd10;
    localparam logic [3:0] ST_HDR_NL     = 4'd11;
    localparam logic [3:0] ST_HDR_GT     = 4'd12;
    localparam logic [3:0] ST_HDR_NAME   = 4'd13;
    localparam logic [3:0] ST_HDR_END    = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       in_hdr;
    logic       acc;
    logic       do_read;

    assign in_hdr   = state_reg inside {ST_HDR_NL, ST_HDR_GT, ST_HDR_NAME, ST_HDR_END};
    assign s_tready = !in_hdr && !full;
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        push       = 1'b0;
        do_read    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_NAME:
            begin
                if (acc)
                begin
                    if (sts.is_tab)
                    begin
                        cmd.pos_clr = 1'b1;
                        if (sts.hdr_needed)
                        begin
                            cmd.name_commit = 1'b1;
                            state_next      = sts.record_open ? ST_HDR_NL : ST_HDR_GT;
                        end
                        else
                        begin
                            state_next = ST_POS;
                        end
                    end
                    else if (sts.name_room)
                    begin
                        cmd.name_wr = 1'b1;
                    end
                end
            end
            ST_POS:
            begin
                if (acc)
                begin
                    if (sts.is_digit)
                    begin
                        cmd.pos_digit = 1'b1;
                    end
                    else
                    begin
                        cmd.pos_finish = 1'b1;
                        if (sts.run_needed)
                        begin
                            push        = 1'b1;
                            cmd.res_sel = pcc_pkg::RES_RUN;
                        end
                        state_next = sts.is_tab ? ST_REF : ST_POS_SKIP;
                    end
                end
            end
            ST_POS_SKIP:
            begin
                if (acc && sts.is_tab)
                begin
                    state_next = ST_REF;
                end
            end
            ST_REF:
            begin
                if (acc)
                begin
                    cmd.ref_load = 1'b1;
                    state_next   = ST_REF_SKIP;
                end
            end
            ST_REF_SKIP:
            begin
                if (acc && sts.is_tab)
                begin
                    state_next = ST_DEPTH_SKIP;
                end
            end
            ST_DEPTH_SKIP:
            begin
                if (acc && sts.is_tab)
                begin
                    state_next = ST_READS;
                end
            end
            ST_READS:
            begin
                do_read = acc;
            end
            ST_INDEL_NUM:
            begin
                if (acc)
                begin
                    if (sts.is_digit)
                    begin
                        cmd.skip_digit = 1'b1;
                    end
                    else if (!sts.skip_zero)
                    begin
                        cmd.skip_dec = 1'b1;
                        state_next   = sts.skip_one ? ST_READS : ST_INDEL_SKIP;
                    end
                    else
                    begin
                        do_read = 1'b1;
                    end
                end
            end
            ST_INDEL_SKIP:
            begin
                if (acc)
                begin
                    cmd.skip_dec = 1'b1;
                    if (sts.skip_one || sts.skip_zero)
                    begin
                        state_next = ST_READS;
                    end
                end
            end
            ST_QUAL:
            begin
                if (acc)
                begin
                    state_next = ST_READS;
                end
            end
            ST_TRAIL:
            begin
                if (acc && sts.is_nl)
                begin
                    cmd.line_end = 1'b1;
                    cmd.res_sel  = pcc_pkg::RES_CONS;
                    push         = 1'b1;
                    state_next   = ST_NAME;
                end
            end
            ST_HDR_NL:
            begin
                cmd.hdr_mode = 1'b1;
                if (!full)
                begin
                    push        = 1'b1;
                    cmd.res_sel = pcc_pkg::RES_NL;
                    state_next  = ST_HDR_GT;
                end
            end
            ST_HDR_GT:
            begin
                cmd.hdr_mode = 1'b1;
                if (!full)
                begin
                    push        = 1'b1;
                    cmd.res_sel = pcc_pkg::RES_GT;
                    state_next  = sts.name_empty ? ST_HDR_END : ST_HDR_NAME;
                end
            end
            ST_HDR_NAME:
            begin
                cmd.hdr_mode = 1'b1;
                if (!full)
                begin
                    push        = 1'b1;
                    cmd.res_sel = pcc_pkg::RES_NAME;
                    if (sts.hdr_last)
                    begin
                        state_next = ST_HDR_END;
                    end
                    else
                    begin
                        cmd.hdr_inc = 1'b1;
                    end
                end
            end
            ST_HDR_END:
            begin
                cmd.hdr_mode = 1'b1;
                if (!full)
                begin
                    push        = 1'b1;
                    cmd.res_sel = pcc_pkg::RES_END;
                    state_next  = ST_POS;
                end
            end
            default:
            begin
                state_next = ST_NAME;
            end
        endcase

        // read-bases byte
        if (do_read)
        begin
            state_next = ST_READS;
            if (sts.is_nl)
            begin
                cmd.line_end = 1'b1;
                cmd.res_sel  = pcc_pkg::RES_CONS;
                push         = 1'b1;
                state_next   = ST_NAME;
            end
            else if (sts.is_tab)
            begin
                state_next = ST_TRAIL;
            end
            else if (sts.is_indel)
            begin
                cmd.skip_clr = 1'b1;
                state_next   = ST_INDEL_NUM;
            end
            else if (sts.is_caret)
            begin
                state_next = ST_QUAL;
            end
            else
            begin
                cmd.bump_read = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_NAME;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
